FILE: rtl/spp_pkg.sv
// Shared constants and types for the stereographic point projection core.
package spp_pkg;

    localparam int REG_W   = 64;
    localparam int NUM_REGS = 8;
    localparam int IDX_W   = 3;
    localparam int VIEW_W  = 62;

    localparam int XF_W    = 30;
    localparam int SQ_W    = 60;
    localparam int RT_W    = SQ_W / 2;
    localparam int D_W     = 31;
    localparam int Q_W     = 43;
    localparam int NUM_W   = XF_W + 28 + 9;
    localparam int HI_W    = NUM_W - Q_W;

    typedef logic [REG_W-1:0] t_reg;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx REG_ROW_X_AB = 3'd0;
    localparam t_idx REG_ROW_X_CD = 3'd1;
    localparam t_idx REG_ROW_Y_AB = 3'd2;
    localparam t_idx REG_ROW_Y_CD = 3'd3;
    localparam t_idx REG_ROW_Z_AB = 3'd4;
    localparam t_idx REG_ROW_Z_CD = 3'd5;
    localparam t_idx REG_VIEW     = 3'd6;
    localparam t_idx REG_DEPTH    = 3'd7;

    localparam t_reg RST_ROW_X_AB = 64'd268435456;
    localparam t_reg RST_ROW_X_CD = 64'd0;
    localparam t_reg RST_ROW_Y_AB = 64'd1152921504606846976;
    localparam t_reg RST_ROW_Y_CD = 64'd0;
    localparam t_reg RST_ROW_Z_AB = 64'd0;
    localparam t_reg RST_ROW_Z_CD = 64'd268435456;
    localparam t_reg RST_VIEW     = 64'd1099511627776;
    localparam t_reg RST_DEPTH    = 64'd4611686018427387904;

    typedef logic [5:0][REG_W-1:0] t_rows;

endpackage

FILE: rtl/spp_xform.sv
// Two-stage affine transform of one point by the 3x4 matrix.
module spp_xform (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  spp_pkg::t_rows                i_rows,
    input  logic signed [31:0]            i_vx,
    input  logic signed [31:0]            i_vy,
    input  logic signed [31:0]            i_vz,
    output logic                          o_valid,
    output logic signed [spp_pkg::XF_W-1:0] o_x,
    output logic signed [spp_pkg::XF_W-1:0] o_y,
    output logic signed [spp_pkg::XF_W-1:0] o_z
);

    logic                    r_v1;
    logic signed [63:0]      r_p [3][4];
    logic signed [63:0]      n_p [3][4];
    logic signed [65:0]      n_s [3];
    logic signed [spp_pkg::XF_W-1:0] r_o [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_p[k][0] = $signed(i_rows[2*k][31:0]) * i_vx;
            n_p[k][1] = $signed(i_rows[2*k][63:32]) * i_vy;
            n_p[k][2] = $signed(i_rows[2*k+1][31:0]) * i_vz;
            n_p[k][3] = $signed({{4{i_rows[2*k+1][63]}}, i_rows[2*k+1][63:32], 28'd0});
            n_s[k] = r_p[k][0] + r_p[k][1] + r_p[k][2] + r_p[k][3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
        r_p <= n_p;
        for (int k = 0; k < 3; k++) begin
            r_o[k] <= n_s[k][36 +: spp_pkg::XF_W];
        end
    end

    assign o_x = r_o[0];
    assign o_y = r_o[1];
    assign o_z = r_o[2];

endmodule

FILE: rtl/spp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module spp_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [spp_pkg::SQ_W-1:0]    i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [spp_pkg::RT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int NS = spp_pkg::RT_W;

    logic                     r_v    [NS];
    logic [30:0]              r_rem  [NS];
    logic [NS-1:0]            r_root [NS];
    logic [spp_pkg::SQ_W-1:0] r_rad  [NS];
    logic [SIDE_W-1:0]        r_side [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic                     v_in;
        logic [30:0]              rem_in;
        logic [NS-1:0]            root_in;
        logic [spp_pkg::SQ_W-1:0] rad_in;
        logic [SIDE_W-1:0]        side_in;
        logic [32:0]              cur;
        logic [32:0]              trial;
        logic                     ge;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign rad_in  = r_rad[s-1];
            assign side_in = r_side[s-1];
        end

        assign cur   = {rem_in, rad_in[spp_pkg::SQ_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_in;
            end
            r_rem[s]  <= ge ? 31'(cur - trial) : cur[30:0];
            r_root[s] <= {root_in[NS-2:0], ge};
            r_rad[s]  <= {rad_in[spp_pkg::SQ_W-3:0], 2'b00};
            r_side[s] <= side_in;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

FILE: rtl/spp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module spp_div #(
    parameter int SIDE_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [spp_pkg::HI_W-1:0]   i_hi,
    input  logic [spp_pkg::Q_W-1:0]    i_lo,
    input  logic [spp_pkg::D_W-1:0]    i_den,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [spp_pkg::Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int NS = spp_pkg::Q_W;
    localparam int DW = spp_pkg::D_W;

    logic              r_v    [NS];
    logic [DW-1:0]     r_rem  [NS];
    logic [NS-1:0]     r_lo   [NS];
    logic [NS-1:0]     r_quo  [NS];
    logic [DW-1:0]     r_den  [NS];
    logic [SIDE_W-1:0] r_side [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic              v_in;
        logic [DW-1:0]     rem_in;
        logic [NS-1:0]     lo_in;
        logic [NS-1:0]     quo_in;
        logic [DW-1:0]     den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DW:0]       cur;
        logic              ge;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = DW'(i_hi);
            assign lo_in   = i_lo;
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign rem_in  = r_rem[s-1];
            assign lo_in   = r_lo[s-1];
            assign quo_in  = r_quo[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
        end

        assign cur = {rem_in, lo_in[NS-1]};
        assign ge  = cur >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_in;
            end
            r_rem[s]  <= ge ? DW'(cur - {1'b0, den_in}) : cur[DW-1:0];
            r_lo[s]   <= {lo_in[NS-2:0], 1'b0};
            r_quo[s]  <= {quo_in[NS-2:0], ge};
            r_den[s]  <= den_in;
            r_side[s] <= side_in;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

FILE: rtl/stereographic_point_projection_core.sv
// Top level of the stereographic point projection core.
//
// Usage: drive i_vec_x/y/z with a Q4.28 point and pulse i_start; o_busy is
// always low, so a new transaction may start in every clock cycle.
// Each transaction produces one result after it is accepted:
// o_valid is high for one cycle with o_visible, o_win_x, o_win_y and
// o_win_depth (Q16.16, saturated). Results come out in start order.
// The latency is set by the 30-stage square root and the 43-stage
// divider pipelines, plus eight stages of multiply and add around them.
// Throughput is one transaction per cycle.
// Configuration: write i_cfg_data to register i_cfg_index with i_cfg_we,
// only while no transaction is in flight.
// Reset (synchronous, active low) restores the identity matrix, unit scale
// and unit depth range, and drops every transaction in flight.
// The receiver has no back-pressure: results must be taken when shown.
module stereographic_point_projection_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [31:0]       i_vec_x,
    input  logic signed [31:0]       i_vec_y,
    input  logic signed [31:0]       i_vec_z,
    input  logic                     i_cfg_we,
    input  spp_pkg::t_idx            i_cfg_index,
    input  spp_pkg::t_reg            i_cfg_data,
    output logic                     o_valid,
    output logic                     o_visible,
    output logic signed [31:0]       o_win_x,
    output logic signed [31:0]       o_win_y,
    output logic signed [31:0]       o_win_depth
);

    localparam int XW  = spp_pkg::XF_W;
    localparam int DW  = spp_pkg::D_W;
    localparam int QW  = spp_pkg::Q_W;
    localparam int NW  = spp_pkg::NUM_W;
    localparam int RW  = spp_pkg::RT_W;
    localparam int XS_W = 1 + 1 + 32 + 1;

    spp_pkg::t_reg r_cfg [spp_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[spp_pkg::REG_ROW_X_AB] <= spp_pkg::RST_ROW_X_AB;
            r_cfg[spp_pkg::REG_ROW_X_CD] <= spp_pkg::RST_ROW_X_CD;
            r_cfg[spp_pkg::REG_ROW_Y_AB] <= spp_pkg::RST_ROW_Y_AB;
            r_cfg[spp_pkg::REG_ROW_Y_CD] <= spp_pkg::RST_ROW_Y_CD;
            r_cfg[spp_pkg::REG_ROW_Z_AB] <= spp_pkg::RST_ROW_Z_AB;
            r_cfg[spp_pkg::REG_ROW_Z_CD] <= spp_pkg::RST_ROW_Z_CD;
            r_cfg[spp_pkg::REG_VIEW]     <= spp_pkg::RST_VIEW;
            r_cfg[spp_pkg::REG_DEPTH]    <= spp_pkg::RST_DEPTH;
        end else if (i_cfg_we) begin
            if (i_cfg_index == spp_pkg::REG_VIEW) begin
                r_cfg[i_cfg_index] <= {2'b00, i_cfg_data[spp_pkg::VIEW_W-1:0]};
            end else begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    spp_pkg::t_rows rows;
    logic [27:0]        scale;
    logic               flip_x;
    logic               flip_y;
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic signed [31:0] near;
    logic [31:0]        inv_range;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            rows[k] = r_cfg[k];
        end
    end
    assign center_x  = r_cfg[spp_pkg::REG_VIEW][15:0];
    assign center_y  = r_cfg[spp_pkg::REG_VIEW][31:16];
    assign scale     = r_cfg[spp_pkg::REG_VIEW][59:32];
    assign flip_x    = r_cfg[spp_pkg::REG_VIEW][60];
    assign flip_y    = r_cfg[spp_pkg::REG_VIEW][61];
    assign near      = r_cfg[spp_pkg::REG_DEPTH][31:0];
    assign inv_range = r_cfg[spp_pkg::REG_DEPTH][63:32];

    assign o_busy = 1'b0;

    // transform
    logic                 xf_v;
    logic signed [XW-1:0] xf_x, xf_y, xf_z;

    spp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_rows  (rows),
        .i_vx    (i_vec_x),
        .i_vy    (i_vec_y),
        .i_vz    (i_vec_z),
        .o_valid (xf_v),
        .o_x     (xf_x),
        .o_y     (xf_y),
        .o_z     (xf_z)
    );

    // squares, then their sum
    logic                   r_v3, r_v4;
    logic [2*XW-1:0]        r_sq [3];
    logic signed [XW-1:0]   r_x3, r_y3, r_z3, r_x4, r_y4, r_z4;
    logic [spp_pkg::SQ_W-1:0] r_rad4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= xf_v;
            r_v4 <= r_v3;
        end
        r_sq[0] <= (2*XW)'(xf_x * xf_x);
        r_sq[1] <= (2*XW)'(xf_y * xf_y);
        r_sq[2] <= (2*XW)'(xf_z * xf_z);
        r_x3 <= xf_x;
        r_y3 <= xf_y;
        r_z3 <= xf_z;
        r_rad4 <= spp_pkg::SQ_W'(r_sq[0] + r_sq[1] + r_sq[2]);
        r_x4 <= r_x3;
        r_y4 <= r_y3;
        r_z4 <= r_z3;
    end

    // radius
    logic                 sq_v;
    logic [RW-1:0]        sq_r;
    logic [3*XW-1:0]      sq_side;

    spp_isqrt #(.SIDE_W(3*XW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_rad   (r_rad4),
        .i_side  ({r_x4, r_y4, r_z4}),
        .o_valid (sq_v),
        .o_root  (sq_r),
        .o_side  (sq_side)
    );

    logic signed [XW-1:0] sx, sy, sz;
    logic signed [31:0]   n_d5;
    logic signed [36:0]   n_diff5;

    assign sx = sq_side[3*XW-1 -: XW];
    assign sy = sq_side[2*XW-1 -: XW];
    assign sz = sq_side[XW-1:0];
    assign n_d5    = $signed({2'b00, sq_r}) - 32'(sz);
    assign n_diff5 = $signed({7'd0, sq_r}) - $signed({near[31], near, 4'd0});

    // stage 5: h, magnitudes
    logic          r_v5, r_v6, r_v7;
    logic [31:0]   r_d5;
    logic [XW-1:0] r_ax5, r_ay5;
    logic          r_nx5, r_ny5, r_dn5;
    logic [35:0]   r_da5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v5 <= sq_v;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
        r_d5  <= n_d5;
        r_nx5 <= sx[XW-1];
        r_ny5 <= sy[XW-1];
        r_ax5 <= sx[XW-1] ? XW'(-sx) : XW'(sx);
        r_ay5 <= sy[XW-1] ? XW'(-sy) : XW'(sy);
        r_dn5 <= n_diff5[36];
        r_da5 <= n_diff5[36] ? 36'(-n_diff5) : n_diff5[35:0];
    end

    // stage 6: products
    logic [XW+27:0] r_px6, r_py6;
    logic [49:0]    r_ph6, r_pl6;
    logic [DW-1:0]  r_d6;
    logic           r_nx6, r_ny6, r_dn6;

    always_ff @(posedge i_clk) begin
        r_px6 <= r_ax5 * scale;
        r_py6 <= r_ay5 * scale;
        r_ph6 <= r_da5[35:18] * inv_range;
        r_pl6 <= r_da5[17:0] * inv_range;
        r_d6  <= r_d5[DW-1:0];
        r_nx6 <= r_nx5;
        r_ny6 <= r_ny5;
        r_dn6 <= r_dn5;
    end

    // stage 7: depth and divider setup
    logic [50:0]   n_u7;
    logic [34:0]   n_m7;
    logic [31:0]   n_dep7;
    logic [NW-1:0] n_nx7, n_ny7;

    always_comb begin
        n_u7 = 51'(r_ph6) + 51'(r_pl6 >> 18);
        n_m7 = n_u7[50:16];
        if (r_dn6) begin
            n_dep7 = (n_m7 > 35'h080000000) ? 32'h8000_0000 : 32'(-n_m7);
        end else begin
            n_dep7 = (n_m7 > 35'h07fffffff) ? 32'h7fff_ffff : n_m7[31:0];
        end
        n_nx7 = {r_px6, 9'd0};
        n_ny7 = {r_py6, 9'd0};
    end

    logic [NW-1:0]  r_nx7, r_ny7;
    logic [DW-1:0]  r_d7;
    logic [XS_W-1:0] r_xs7;
    logic [1:0]     r_ys7;

    always_ff @(posedge i_clk) begin
        r_nx7 <= n_nx7;
        r_ny7 <= n_ny7;
        r_d7  <= r_d6;
        r_xs7 <= {r_d6 != '0, r_nx6, n_dep7, DW'(n_nx7[NW-1:QW]) >= r_d6};
        r_ys7 <= {r_ny6, DW'(n_ny7[NW-1:QW]) >= r_d6};
    end

    // division
    logic            dx_v, dy_v;
    logic [QW-1:0]   dx_q, dy_q;
    logic [XS_W-1:0] dx_s;
    logic [1:0]      dy_s;

    spp_div #(.SIDE_W(XS_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_hi    (r_nx7[NW-1:QW]),
        .i_lo    (r_nx7[QW-1:0]),
        .i_den   (r_d7),
        .i_side  (r_xs7),
        .o_valid (dx_v),
        .o_quo   (dx_q),
        .o_side  (dx_s)
    );

    spp_div #(.SIDE_W(2)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_hi    (r_ny7[NW-1:QW]),
        .i_lo    (r_ny7[QW-1:0]),
        .i_den   (r_d7),
        .i_side  (r_ys7),
        .o_valid (dy_v),
        .o_quo   (dy_q),
        .o_side  (dy_s)
    );

    function automatic logic [31:0] win_out(input logic [QW-1:0] q, input logic sat,
                                            input logic neg, input logic [15:0] ctr);
        logic [QW-1:0]      m;
        logic signed [44:0] val;
        logic signed [44:0] sum;
        m   = (sat || q[QW-1]) ? {1'b1, {(QW-1){1'b0}}} : q;
        val = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        sum = val + $signed({13'd0, ctr, 16'd0});
        if (sum > 45'sh0_7FFF_FFFF) begin
            return 32'h7fff_ffff;
        end else if (sum < -45'sh0_8000_0000) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

    logic        fin_vis;
    logic [31:0] n_wx, n_wy;

    assign fin_vis = dx_s[XS_W-1];
    assign n_wx = win_out(dx_q, dx_s[0], dx_s[XS_W-2] != flip_x, center_x);
    assign n_wy = win_out(dy_q, dy_s[0], dy_s[1] != flip_y, center_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dx_v && dy_v;
        end
        o_visible   <= fin_vis;
        o_win_x     <= fin_vis ? n_wx : '0;
        o_win_y     <= fin_vis ? n_wy : '0;
        o_win_depth <= fin_vis ? dx_s[32:1] : '0;
    end

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dx_v == dy_v) else $error("divider lanes out of step");

    a_h_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> !r_d5[31]) else $error("negative h");

    a_invisible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_win_x == 0 && o_win_y == 0 && o_win_depth == 0))
        else $error("invisible point with nonzero fields");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 81)) else $error("result without a start");

endmodule

FILE: tb/sv/stereographic_point_projection_core_tb.sv
// Self-checking testbench for the stereographic point projection core.
module stereographic_point_projection_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 81;

    typedef struct packed {
        logic        visible;
        logic [31:0] win_x;
        logic [31:0] win_y;
        logic [31:0] win_depth;
    } t_proj;

    typedef struct {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        bit          known;
        t_proj       want;
    } t_row;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [31:0]   vec_x = '0, vec_y = '0, vec_z = '0;
    logic          cfg_we = 1'b0;
    spp_pkg::t_idx cfg_index = spp_pkg::REG_ROW_X_AB;
    spp_pkg::t_reg cfg_data = '0;
    logic          res_valid, res_visible;
    logic [31:0]   res_win_x, res_win_y, res_win_depth;

    spp_pkg::t_reg shadow_regs [spp_pkg::NUM_REGS];
    t_proj  pending_proj [$];
    int     fail_count = 0;
    int     idle_pct = 0;

    stereographic_point_projection_core DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_vec_x(vec_x), .i_vec_y(vec_y), .i_vec_z(vec_z),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(res_valid), .o_visible(res_visible), .o_win_x(res_win_x),
        .o_win_y(res_win_y), .o_win_depth(res_win_depth)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [63:0] floor36(logic signed [127:0] p);
        return 64'(p >>> 36);
    endfunction

    function automatic logic signed [63:0] matrix_row(spp_pkg::t_reg ab, spp_pkg::t_reg cd,
            logic signed [31:0] v0, logic signed [31:0] v1, logic signed [31:0] v2);
        logic signed [127:0] acc;
        acc = $signed(ab[31:0]) * v0 + $signed(ab[63:32]) * v1
            + $signed(cd[31:0]) * v2 + ($signed(cd[63:32]) <<< 28);
        return floor36(acc);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7fffffff;
        if (v < -128'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] window_coord(logic signed [63:0] c, logic [27:0] scale,
            logic [63:0] d, logic flip, logic [15:0] center);
        logic        neg;
        logic [127:0] a, n, q, rem, m;
        logic signed [127:0] val;
        neg = c < 0;
        a = neg ? 128'(-c) : 128'(c);
        n = a * scale;
        q = n / d;
        rem = n % d;
        if (q >= (128'd1 << 33)) m = 128'd1 << 42;
        else m = (q << 9) + (rem << 9) / d;
        val = (neg != flip) ? -$signed(m) : $signed(m);
        return clamp32($signed({112'd0, center}) * 65536 + val);
    endfunction

    function automatic t_proj project_point(logic [31:0] vx, logic [31:0] vy,
            logic [31:0] vz);
        t_proj p;
        logic signed [63:0] x, y, z, r, d, diff;
        logic [63:0] a, inv, u, m;
        spp_pkg::t_reg view, dep;
        x = matrix_row(shadow_regs[spp_pkg::REG_ROW_X_AB], shadow_regs[spp_pkg::REG_ROW_X_CD],
                       vx, vy, vz);
        y = matrix_row(shadow_regs[spp_pkg::REG_ROW_Y_AB], shadow_regs[spp_pkg::REG_ROW_Y_CD],
                       vx, vy, vz);
        z = matrix_row(shadow_regs[spp_pkg::REG_ROW_Z_AB], shadow_regs[spp_pkg::REG_ROW_Z_CD],
                       vx, vy, vz);
        r = root_floor(x * x + y * y + z * z);
        d = r - z;
        p = '0;
        if (d <= 0) return p;
        view = shadow_regs[spp_pkg::REG_VIEW];
        dep = shadow_regs[spp_pkg::REG_DEPTH];
        p.visible = 1'b1;
        p.win_x = window_coord(x, view[59:32], d, view[60], view[15:0]);
        p.win_y = window_coord(y, view[59:32], d, view[61], view[31:16]);
        diff = r - $signed(dep[31:0]) * 16;
        a = diff < 0 ? -diff : diff;
        inv = dep[63:32];
        u = (a >> 18) * inv + (((a & 64'h3ffff) * inv) >> 18);
        m = u >> 16;
        p.win_depth = clamp32(diff < 0 ? -$signed({64'd0, m}) : $signed({64'd0, m}));
        return p;
    endfunction

    task automatic write_reg(spp_pkg::t_idx idx, spp_pkg::t_reg value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        shadow_regs[idx] = (idx == spp_pkg::REG_VIEW) ?
                           (value & ((64'd1 << spp_pkg::VIEW_W) - 1)) : value;
        @(posedge clk);
    endtask

    task automatic send_point(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
            bit known, t_proj want);
        cfg_we <= 1'b0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        vec_x <= vx;
        vec_y <= vy;
        vec_z <= vz;
        pending_proj.push_back(known ? want : project_point(vx, vy, vz));
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        cfg_we <= 1'b0;
        while (pending_proj.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk) begin
        t_proj exp_p;
        if (rst_n && res_valid) begin
            if (pending_proj.size() == 0) begin
                $error("unexpected transaction");
                fail_count++;
            end else begin
                exp_p = pending_proj.pop_front();
                if (res_visible !== exp_p.visible) begin
                    $error("visible exp %0h got %0h", exp_p.visible, res_visible);
                    fail_count++;
                end
                if (res_win_x !== exp_p.win_x) begin
                    $error("win_x exp %0h got %0h", exp_p.win_x, res_win_x);
                    fail_count++;
                end
                if (res_win_y !== exp_p.win_y) begin
                    $error("win_y exp %0h got %0h", exp_p.win_y, res_win_y);
                    fail_count++;
                end
                if (res_win_depth !== exp_p.win_depth) begin
                    $error("win_depth exp %0h got %0h", exp_p.win_depth, res_win_depth);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 29)) - (1 << 28));
            2: return 32'($signed($urandom_range(4096)) - 2048);
            3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic spp_pkg::t_reg rand_row();
        spp_pkg::t_reg v;
        v = {$urandom, $urandom};
        if ($urandom_range(1)) begin
            v[31:0] = 32'($signed($urandom_range(1 << 29)) - (1 << 28));
            v[63:32] = 32'($signed($urandom_range(1 << 29)) - (1 << 28));
        end
        return v;
    endfunction

    t_row directed [13] = '{
        '{32'h0, 32'h0, 32'h0, 1'b1, t_proj'('0)},
        '{32'h0, 32'h0, 32'h10000000, 1'b1, t_proj'('0)},
        '{32'h0, 32'h0, 32'h7fffffff, 1'b1, t_proj'('0)},
        '{32'h10000000, 32'h0, 32'h0, 1'b0, t_proj'('0)},
        '{32'h0, 32'h0, 32'hf0000000, 1'b0, t_proj'('0)},
        '{32'h0, 32'h0, 32'h80000000, 1'b0, t_proj'('0)},
        '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, t_proj'('0)},
        '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, t_proj'('0)},
        '{32'h7fffffff, 32'h80000000, 32'h0, 1'b0, t_proj'('0)},
        '{32'h00000010, 32'h0, 32'h10000000, 1'b0, t_proj'('0)},
        '{32'h10000000, 32'h0, 32'h0fffffff, 1'b0, t_proj'('0)},
        '{32'hffffffff, 32'h00000001, 32'hfffffffe, 1'b0, t_proj'('0)},
        '{32'h55555555, 32'haaaaaaaa, 32'h12345678, 1'b0, t_proj'('0)}
    };

    initial begin
        #50ms;
        $display("stereographic_point_projection_core test failed");
        $finish;
    end

    initial begin
        shadow_regs = '{spp_pkg::RST_ROW_X_AB, spp_pkg::RST_ROW_X_CD,
                        spp_pkg::RST_ROW_Y_AB, spp_pkg::RST_ROW_Y_CD,
                        spp_pkg::RST_ROW_Z_AB, spp_pkg::RST_ROW_Z_CD,
                        spp_pkg::RST_VIEW, spp_pkg::RST_DEPTH};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_point(directed[i].vx, directed[i].vy, directed[i].vz,
                       directed[i].known, directed[i].want);
        drain();
        // extremes of view and depth setup, tiny h for saturation
        write_reg(spp_pkg::REG_VIEW, 64'hffff_ffff_ffff_ffff);
        write_reg(spp_pkg::REG_DEPTH, 64'hffff_ffff_8000_0000);
        send_point(32'h00001000, 32'h00001000, 32'h0fffffff, 1'b0, '0);
        send_point(32'hfffff000, 32'hfffff000, 32'h0fffffff, 1'b0, '0);
        send_point(32'h7fffffff, 32'h80000000, 32'h80000000, 1'b0, '0);
        drain();
        write_reg(spp_pkg::REG_DEPTH, 64'h0000_0000_7fff_ffff);
        write_reg(spp_pkg::REG_VIEW, 64'h0);
        send_point(32'h01000000, 32'h0, 32'h0, 1'b0, '0);
        drain();
        for (int ph = 0; ph < 26; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 55;
                2: idle_pct = 29;
                default: idle_pct = $urandom_range(1) ? 0 : 55;
            endcase
            if (ph % 3 == 2) begin
                for (int k = 0; k < 6; k++) write_reg(spp_pkg::t_idx'(k), rand_row());
            end else if (ph % 3 == 1) begin
                write_reg(spp_pkg::REG_ROW_X_AB, spp_pkg::RST_ROW_X_AB);
                write_reg(spp_pkg::REG_ROW_X_CD,
                          {32'($signed($urandom_range(1 << 26)) - (1 << 25)), 32'd0});
                write_reg(spp_pkg::REG_ROW_Y_AB, spp_pkg::RST_ROW_Y_AB);
                write_reg(spp_pkg::REG_ROW_Y_CD, 64'd0);
                write_reg(spp_pkg::REG_ROW_Z_AB, 64'd0);
                write_reg(spp_pkg::REG_ROW_Z_CD, spp_pkg::RST_ROW_Z_CD);
            end
            write_reg(spp_pkg::REG_VIEW, {$urandom, $urandom});
            write_reg(spp_pkg::REG_DEPTH, {$urandom, $urandom});
            for (int n = 0; n < 50; n++)
                send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
            drain();
        end
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0 && pending_proj.size() == 0)
            $display("stereographic_point_projection_core test passed");
        else
            $display("stereographic_point_projection_core test failed");
        $finish;
    end
endmodule

FILE: stereographic_point_projection_core.f
rtl/spp_pkg.sv
rtl/spp_xform.sv
rtl/spp_isqrt.sv
rtl/spp_div.sv
rtl/stereographic_point_projection_core.sv
tb/sv/stereographic_point_projection_core_tb.sv
